// ===== src/cps_pkg.sv =====
package cps_pkg;

  // Field widths of the stream words
  localparam int DUR_W  = 16;
  localparam int FIN_W  = 22;
  localparam int PIDX_W = 6;
  localparam int PRQ_W  = 7;

  // Saturation point of a finish time
  localparam logic [FIN_W-1:0] FIN_MAX = 22'h3FFFFF;

  // Command queue depth between front and back
  localparam int QDEPTH = 4;

  // Defaults for the top-level parameters
  localparam int MAX_COURSES_DEF   = 64;
  localparam int MAX_EDGES_DEF     = 256;
  localparam int DURATION_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_HDR,
    OP_EDGE,
    OP_NOP
  } op_t;

  // Classified load command
  typedef struct packed {
    op_t               op;
    logic [DUR_W-1:0]  dur;
    logic [PIDX_W-1:0] pidx;
    logic              last;
  } cmd_t;

endpackage

// ===== src/critical_path_scheduler.sv =====
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tdata {prereq,dep_count,duration}, tuser kind, tlast last
// m        out  m_tvalid/m_tready  tdata {critical,finish_time}, tlast last_out
//
// Load words are taken one per cycle, while the queue has room, into a small
// command queue; the back end writes one course or edge per cycle while in its
// load state. The tlast word starts the compute once a course is stored: init,
// edge counting, the ready scan, per dequeued course a sweep over the stored
// edges, then the path trace and the results. The edge sweeps set the compute
// time. rst is synchronous; outputs stall on m_tready without losing a result.
module critical_path_scheduler #(
  parameter int MAX_COURSES   = cps_pkg::MAX_COURSES_DEF,
  parameter int MAX_EDGES     = cps_pkg::MAX_EDGES_DEF,
  parameter int DURATION_BITS = cps_pkg::DURATION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // duration[15:0], dep_count[21:16], prereq[28:22]
  input  logic        s_tuser,   // kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // finish_time[21:0], critical[22]
  output logic        m_tlast
);

  logic          f_valid;
  logic          f_ready;
  cps_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  cps_pkg::cmd_t q_cmd;

  cps_front #(
    .MAX_COURSES  (MAX_COURSES),
    .DURATION_BITS(DURATION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  cps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_cmd   (f_cmd),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_cmd  (q_cmd)
  );

  cps_back #(
    .MAX_COURSES(MAX_COURSES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== src/cps_front.sv =====
module cps_front #(
  parameter int MAX_COURSES   = cps_pkg::MAX_COURSES_DEF,
  parameter int DURATION_BITS = cps_pkg::DURATION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,
  input  logic          s_tuser,
  input  logic          s_tlast,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cps_pkg::cmd_t cmd
);

  localparam logic [cps_pkg::DUR_W-1:0] DMASK = (DURATION_BITS >= cps_pkg::DUR_W) ?
      {cps_pkg::DUR_W{1'b1}} : cps_pkg::DUR_W'((32'd1 << DURATION_BITS) - 32'd1);

  logic [cps_pkg::PRQ_W-1:0] prq;
  cps_pkg::cmd_t             cmd_next;

  assign s_tready = !cmd_valid || cmd_ready;
  assign prq      = s_tdata[28:22];

  // Classify the incoming word
  always_comb begin
    cmd_next.dur  = s_tdata[15:0] & DMASK;
    cmd_next.pidx = cps_pkg::PIDX_W'(prq - 7'd1);
    cmd_next.last = s_tlast;
    if (!s_tuser) begin
      cmd_next.op = cps_pkg::OP_HDR;
    end else if (prq != 7'd0 && prq <= cps_pkg::PRQ_W'(MAX_COURSES)) begin
      cmd_next.op = cps_pkg::OP_EDGE;
    end else begin
      cmd_next.op = cps_pkg::OP_NOP;
    end
  end

  // Hold one classified command
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      cmd_valid <= 1'b1;
      cmd       <= cmd_next;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

endmodule

// ===== src/cps_queue.sv =====
module cps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cps_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output cps_pkg::cmd_t out_cmd
);

  localparam int PW = $clog2(cps_pkg::QDEPTH);
  localparam int CNTW = $clog2(cps_pkg::QDEPTH + 1);

  cps_pkg::cmd_t   slots [cps_pkg::QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = count != CNTW'(cps_pkg::QDEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= in_cmd;
        wptr        <= PW'(wptr + 1'b1);
      end
      if (pop) begin
        rptr <= PW'(rptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNTW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNTW'(count - 1'b1);
      end
    end
  end

endmodule

// ===== src/cps_back.sv =====
module cps_back #(
  parameter int MAX_COURSES = cps_pkg::MAX_COURSES_DEF,
  parameter int MAX_EDGES   = cps_pkg::MAX_EDGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cps_pkg::cmd_t cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,
  output logic          m_tlast
);

  localparam int CIDX = $clog2(MAX_COURSES);
  localparam int CW   = $clog2(MAX_COURSES + 1);
  localparam int EIDX = $clog2(MAX_EDGES);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] NONE = {CW{1'b1}};

  typedef struct packed {
    logic [cps_pkg::DUR_W-1:0] dur;
    logic [cps_pkg::FIN_W-1:0] fin;
    logic [EW-1:0]             pend;
    logic [CW-1:0]             best;
    logic                      tie;
    logic                      path;
  } rec_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT_RD, S_INIT_WR, S_CNT_E, S_CNT_N, S_CNT_W, S_RDY_R, S_RDY_C,
    S_P_HEAD, S_P_CUR, S_P_FIN, S_P_E, S_P_N, S_P_W, S_T_START, S_T_R, S_T_W,
    S_E_R, S_E_O
  } state_t;

  state_t state;

  // Stores
  rec_t              node_mem [MAX_COURSES];
  logic [2*CIDX-1:0] edge_mem [MAX_EDGES];
  logic [CIDX-1:0]   fifo_mem [MAX_COURSES];

  rec_t              node_q;
  logic [2*CIDX-1:0] edge_q;
  logic [CIDX-1:0]   fifo_q;

  logic [CW-1:0] cc;
  logic [EW-1:0] ec;
  logic [CW-1:0] i;
  logic [EW-1:0] e;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] cur;
  logic [CW-1:0] cur_s;
  logic [CW-1:0] node;
  logic [CW-1:0] guard;
  logic [cps_pkg::FIN_W-1:0] cur_fin;
  logic [cps_pkg::FIN_W-1:0] tot_fin;
  logic [CW-1:0] final_c;
  logic          tot_tie;

  // Memory port controls
  logic [CIDX-1:0] node_ra;
  logic            node_we;
  logic [CIDX-1:0] node_wa;
  rec_t            node_wd;
  logic            edge_we;
  logic            mr_en;
  logic [CW-1:0]   mr_idx;
  logic [cps_pkg::FIN_W-1:0] mr_fin;

  logic [CW-1:0]   ef;
  logic [CW-1:0]   es;
  logic [cps_pkg::FIN_W:0]   sum;
  logic [cps_pkg::FIN_W-1:0] tsat;
  rec_t            upd;
  logic            e_done;
  logic            out_free;

  assign cmd_ready = state == S_LOAD;
  assign ef        = CW'(edge_q[2*CIDX-1:CIDX]);
  assign es        = CW'(edge_q[CIDX-1:0]);
  assign e_done    = EW'(e + 1'b1) == ec;
  assign out_free  = !m_tvalid || m_tready;
  assign edge_we   = state == S_LOAD && cmd_valid && cmd.op == cps_pkg::OP_EDGE &&
                     cc != '0 && ec < EW'(MAX_EDGES);

  // Relax one edge into its successor
  always_comb begin
    sum  = {1'b0, cur_fin} + (cps_pkg::FIN_W + 1)'(node_q.dur);
    tsat = sum[cps_pkg::FIN_W] ? cps_pkg::FIN_MAX : sum[cps_pkg::FIN_W-1:0];
    upd      = node_q;
    upd.pend = EW'(node_q.pend - 1'b1);
    if (node_q.fin < tsat) begin
      upd.fin  = tsat;
      upd.best = cur;
      upd.tie  = 1'b0;
    end else if (node_q.fin == tsat) begin
      upd.tie = 1'b1;
    end
  end

  // Drive memory ports per step
  always_comb begin
    node_ra = i[CIDX-1:0];
    node_we = 1'b0;
    node_wa = i[CIDX-1:0];
    node_wd = node_q;
    mr_en   = 1'b0;
    mr_idx  = i;
    mr_fin  = node_q.fin;
    case (state)
      S_LOAD: begin
        if (cmd_valid && cmd.op == cps_pkg::OP_HDR && cc < CW'(MAX_COURSES)) begin
          node_we     = 1'b1;
          node_wa     = cc[CIDX-1:0];
          node_wd     = '0;
          node_wd.dur = cmd.dur;
        end
      end
      S_INIT_WR: begin
        node_we = 1'b1;
        node_wd = '{dur: node_q.dur, fin: cps_pkg::FIN_W'(node_q.dur), pend: '0,
                    best: NONE, tie: 1'b0, path: 1'b0};
      end
      S_CNT_N, S_P_N: begin
        node_ra = es[CIDX-1:0];
      end
      S_CNT_W: begin
        node_we      = 1'b1;
        node_wa      = cur_s[CIDX-1:0];
        node_wd.pend = EW'(node_q.pend + 1'b1);
      end
      S_RDY_C: begin
        mr_en = node_q.pend == '0;
      end
      S_P_CUR: begin
        node_ra = fifo_q;
      end
      S_P_W: begin
        if (node_q.pend != '0) begin
          node_we = 1'b1;
          node_wa = cur_s[CIDX-1:0];
          node_wd = upd;
          mr_en   = upd.pend == '0;
          mr_idx  = cur_s;
          mr_fin  = upd.fin;
        end
      end
      S_T_R: begin
        node_ra = node[CIDX-1:0];
      end
      S_T_W: begin
        node_we      = 1'b1;
        node_wa      = node[CIDX-1:0];
        node_wd.path = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[node_ra];
    if (edge_we) begin
      edge_mem[ec[EIDX-1:0]] <= {cmd.pidx[CIDX-1:0], CIDX'(cc - 1'b1)};
    end
    edge_q <= edge_mem[e[EIDX-1:0]];
    if (mr_en && tail < CW'(MAX_COURSES)) begin
      fifo_mem[tail[CIDX-1:0]] <= mr_idx[CIDX-1:0];
    end
    fifo_q <= fifo_mem[head[CIDX-1:0]];
  end

  // Sequencer: load, init, count, ready scan, queue walk, trace, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cc       <= '0;
      ec       <= '0;
      tail     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_E_O) begin
        m_tvalid <= 1'b0;
      end
      if (mr_en) begin
        if (tail < CW'(MAX_COURSES)) begin
          tail <= CW'(tail + 1'b1);
        end
        if (mr_fin > tot_fin) begin
          tot_tie <= 1'b0;
          tot_fin <= mr_fin;
          final_c <= mr_idx;
        end else if (mr_fin == tot_fin) begin
          tot_tie <= 1'b1;
        end
      end
      case (state)
        S_LOAD: begin
          if (cmd_valid) begin
            if (node_we) begin
              cc <= CW'(cc + 1'b1);
            end
            if (edge_we) begin
              ec <= EW'(ec + 1'b1);
            end
            if (cmd.last && (cc != '0 || node_we)) begin
              state   <= S_INIT_RD;
              i       <= '0;
              tail    <= '0;
              tot_fin <= '0;
              tot_tie <= 1'b0;
              final_c <= NONE;
            end
          end
        end
        S_INIT_RD: begin
          state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          e <= '0;
          if (CW'(i + 1'b1) == cc) begin
            i     <= '0;
            state <= (ec == '0) ? S_RDY_R : S_CNT_E;
          end else begin
            i     <= CW'(i + 1'b1);
            state <= S_INIT_RD;
          end
        end
        S_CNT_E: begin
          state <= S_CNT_N;
        end
        S_CNT_N, S_CNT_W: begin
          if (state == S_CNT_N && ef < cc && es < cc) begin
            cur_s <= es;
            state <= S_CNT_W;
          end else if (e_done) begin
            state <= S_RDY_R;
          end else begin
            e     <= EW'(e + 1'b1);
            state <= S_CNT_E;
          end
        end
        S_RDY_R: begin
          state <= S_RDY_C;
        end
        S_RDY_C: begin
          if (CW'(i + 1'b1) == cc) begin
            head  <= '0;
            state <= S_P_HEAD;
          end else begin
            i     <= CW'(i + 1'b1);
            state <= S_RDY_R;
          end
        end
        S_P_HEAD: begin
          state <= (head == tail) ? S_T_START : S_P_CUR;
        end
        S_P_CUR: begin
          cur   <= CW'(fifo_q);
          state <= S_P_FIN;
        end
        S_P_FIN: begin
          cur_fin <= node_q.fin;
          head    <= CW'(head + 1'b1);
          e       <= '0;
          state   <= (ec == '0) ? S_P_HEAD : S_P_E;
        end
        S_P_E: begin
          state <= S_P_N;
        end
        S_P_N, S_P_W: begin
          if (state == S_P_N && ef == cur && es < cc) begin
            cur_s <= es;
            state <= S_P_W;
          end else if (e_done) begin
            state <= S_P_HEAD;
          end else begin
            e     <= EW'(e + 1'b1);
            state <= S_P_E;
          end
        end
        S_T_START: begin
          node  <= final_c;
          guard <= '0;
          i     <= '0;
          state <= tot_tie ? S_E_R : S_T_R;
        end
        S_T_R: begin
          state <= (node >= cc || guard == CW'(MAX_COURSES)) ? S_E_R : S_T_W;
        end
        S_T_W: begin
          if (node_q.tie) begin
            state <= S_E_R;
          end else begin
            node  <= node_q.best;
            guard <= CW'(guard + 1'b1);
            state <= S_T_R;
          end
        end
        S_E_R: begin
          state <= S_E_O;
        end
        S_E_O: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, node_q.path, node_q.fin};
            m_tlast  <= CW'(i + 1'b1) == cc;
            if (CW'(i + 1'b1) == cc) begin
              cc    <= '0;
              ec    <= '0;
              tail  <= '0;
              state <= S_LOAD;
            end else begin
              i     <= CW'(i + 1'b1);
              state <= S_E_R;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_critical_path_scheduler.sv =====
module tb_critical_path_scheduler;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCRS  = 64;
  localparam int NEDGE = 256;

  // One load word as the sender sees it
  typedef struct {
    bit                      kind;
    bit [cps_pkg::DUR_W-1:0] dur;
    bit [5:0]                dcnt;
    bit [cps_pkg::PRQ_W-1:0] prq;
    bit                      last;
    bit                      drain;
  } load_word_t;

  // One scheduled course as the block should report it
  typedef struct {
    bit [cps_pkg::FIN_W-1:0] fin;
    bit                      crit;
    bit                      lastf;
  } course_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  load_word_t  load_q[$];
  course_res_t sched_q[$];
  int          fails = 0;

  // Graph being loaded by the current data set
  bit [cps_pkg::DUR_W-1:0] dur_mem [NCRS];
  bit [11:0]               edge_q[$];
  int unsigned             ncourse = 0;

  critical_path_scheduler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Longest-path schedule of the loaded graph; queue one result per course
  function automatic void schedule_set();
    int unsigned fin[NCRS], pend[NCRS], bp[NCRS];
    bit          tie[NCRS], mark[NCRS];
    int unsigned rdy[$];
    int unsigned n, head, cur, f, s, node, tot, fc;
    bit          ttie;
    longint unsigned t;
    course_res_t r;
    n = ncourse;
    tot = 0;
    fc = 127;
    ttie = 0;
    head = 0;
    for (int i = 0; i < NCRS; i++) begin
      fin[i] = (i < n) ? dur_mem[i] : 0;
      pend[i] = 0; bp[i] = 127; tie[i] = 0; mark[i] = 0;
    end
    foreach (edge_q[e]) begin
      f = edge_q[e][11:6]; s = edge_q[e][5:0];
      if (f < n && s < n) pend[s]++;
    end
    for (int i = 0; i < n; i++) begin
      if (pend[i] == 0) begin
        rdy.insert(rdy.size(), i);
        if (fin[i] > tot) begin ttie = 0; tot = fin[i]; fc = i; end
        else if (fin[i] == tot) ttie = 1;
      end
    end
    while (head < rdy.size()) begin
      cur = rdy[head];
      head++;
      foreach (edge_q[e]) begin
        f = edge_q[e][11:6]; s = edge_q[e][5:0];
        if (f != cur || f >= n || s >= n || pend[s] == 0) continue;
        pend[s]--;
        t = longint'(fin[cur]) + dur_mem[s];
        if (t > cps_pkg::FIN_MAX) t = cps_pkg::FIN_MAX;
        if (fin[s] < t) begin
          fin[s] = t; bp[s] = cur; tie[s] = 0;
        end else if (fin[s] == t) begin
          tie[s] = 1;
        end
        if (pend[s] == 0) begin
          rdy.insert(rdy.size(), s);
          if (fin[s] > tot) begin ttie = 0; tot = fin[s]; fc = s; end
          else if (fin[s] == tot) ttie = 1;
        end
      end
    end
    // Trace back the critical path unless the finish time is tied
    if (!ttie) begin
      node = fc;
      for (int g = 0; g < NCRS && node < n; g++) begin
        mark[node] = 1;
        if (tie[node]) break;
        node = bp[node];
      end
    end
    for (int i = 0; i < n; i++) begin
      r.fin = fin[i];
      r.crit = mark[i];
      r.lastf = (i + 1 == n);
      sched_q.insert(sched_q.size(), r);
    end
    ncourse = 0;
    edge_q.delete();
  endfunction

  // Apply one accepted load word to the graph
  function automatic void take_word(load_word_t w);
    if (!w.kind) begin
      if (ncourse < NCRS) begin
        dur_mem[ncourse] = w.dur;
        ncourse++;
      end
    end else if (ncourse > 0 && w.prq >= 1 && w.prq <= NCRS && edge_q.size() < NEDGE) begin
      edge_q.insert(edge_q.size(), {6'(w.prq - 1), 6'(ncourse - 1)});
    end
    if (w.last) schedule_set();
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  // Driver: advance the load queue one word per handshake
  int gap_left = 0;
  always @(posedge clk) begin
    load_word_t w;
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_word(load_q.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 0;
        end else if (load_q.size() > 0 && !(load_q[0].drain && sched_q.size() > 0)) begin
          w = load_q[0];
          s_tvalid <= 1;
          s_tdata <= {3'b0, w.prq, w.dcnt, w.dur};
          s_tuser <= w.kind;
          s_tlast <= w.last;
          gap_left = draw_gap();
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  int hold_left = 0;
  always @(posedge clk) begin
    course_res_t r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (sched_q.size() == 0) begin
          $display("%0t: unexpected result fin=%0d crit=%0b last=%0b", $time,
                   m_tdata[21:0], m_tdata[22], m_tlast);
          fails++;
        end else begin
          r = sched_q.pop_front();
          if (m_tdata[21:0] !== r.fin || m_tdata[22] !== r.crit || m_tlast !== r.lastf) begin
            $display("%0t: mismatch expected fin=%0d crit=%0b last=%0b actual fin=%0d crit=%0b last=%0b",
                     $time, r.fin, r.crit, r.lastf, m_tdata[21:0], m_tdata[22], m_tlast);
            fails++;
          end
        end
        hold_left = draw_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  function automatic void add_word(bit k, bit [15:0] d, bit [5:0] c, bit [6:0] p, bit l,
                                   bit dr = 0);
    load_word_t w;
    w.kind = k; w.dur = d; w.dcnt = c; w.prq = p; w.last = l; w.drain = dr;
    load_q.insert(load_q.size(), w);
  endfunction

  // Build a data set of n courses with prerequisites on earlier courses, a bad_pct share of them random
  function automatic void add_set(int n, int maxp, bit short_dur, int bad_pct);
    int np;
    bit [6:0] p;
    for (int i = 0; i < n; i++) begin
      np = $urandom_range(0, (i < maxp) ? i : maxp);
      add_word(0, short_dur ? 16'($urandom_range(0, 3)) : 16'($urandom),
               ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'(np), 7'($urandom), 0);
      for (int j = 0; j < np; j++) begin
        p = 7'($urandom_range(1, i));
        if ($urandom_range(0, 99) < bad_pct) p = 7'($urandom_range(0, 127));
        add_word(1, 16'($urandom), 6'($urandom), p, 0);
      end
    end
    load_q[load_q.size() - 1].last = 1;
  endfunction

  initial begin
    int count;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Prerequisite before any header, then an empty data set
    add_word(1, 16'hFFFF, 6'h3F, 7'd1, 0);
    add_word(1, 16'h0000, 6'h00, 7'd2, 1);
    // Extreme durations, bad prerequisite numbers, a never-loaded course
    add_word(0, 16'hFFFF, 6'h3F, 7'h7F, 0);
    add_word(0, 16'h0000, 6'h00, 7'h00, 0);
    add_word(1, 16'h0000, 6'h00, 7'h00, 0);
    add_word(1, 16'h0000, 6'h00, 7'h7F, 0);
    add_word(1, 16'h0000, 6'h00, 7'd64, 0);
    add_word(1, 16'h0000, 6'h00, 7'd1, 0);
    add_word(0, 16'd5, 6'd1, 7'h00, 0);
    add_word(1, 16'h0000, 6'h00, 7'd2, 1);
    // Header carrying the last mark; single course
    add_word(0, 16'd7, 6'd0, 7'h00, 1, 1);
    // Cycle between two courses beside a free one
    add_word(0, 16'd3, 6'd1, 7'h00, 0);
    add_word(1, 16'h0, 6'd0, 7'd2, 0);
    add_word(0, 16'd4, 6'd1, 7'h00, 0);
    add_word(1, 16'h0, 6'd0, 7'd1, 0);
    add_word(0, 16'd2, 6'd0, 7'h00, 1);
    // Tied finish time, then a tied predecessor on the path
    add_word(0, 16'd6, 6'd0, 7'h00, 0);
    add_word(0, 16'd6, 6'd0, 7'h00, 1);
    add_word(0, 16'd4, 6'd0, 7'h00, 0);
    add_word(0, 16'd4, 6'd0, 7'h00, 0);
    add_word(0, 16'd1, 6'd2, 7'h00, 0);
    add_word(1, 16'h0, 6'd0, 7'd1, 0);
    add_word(1, 16'h0, 6'd0, 7'd2, 1);

    // Random data sets, mostly small, some with broken content
    count = 0;
    while (count < 110) begin
      int n;
      n = load_q.size();
      add_set($urandom_range(1, 8), 3, $urandom_range(0, 1), ($urandom_range(0, 3) == 0) ? 30 : 0);
      if ($urandom_range(0, 9) == 0) add_word(1, 16'($urandom), 6'($urandom), 7'($urandom), 1);
      count += load_q.size() - n;
    end
    load_q[load_q.size() - 1].drain = 1;
    // Overflow the course count once
    add_set(66, 0, 1, 0);
    add_set($urandom_range(2, 6), 2, 0, 0);

    do @(negedge clk); while (load_q.size() > 0 || s_tvalid);
    do @(negedge clk); while (sched_q.size() > 0);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
src/cps_pkg.sv
src/cps_front.sv
src/cps_queue.sv
src/cps_back.sv
src/critical_path_scheduler.sv
tb/tb_critical_path_scheduler.sv
